// ===== sv/kai_pkg.sv =====
package kai_pkg;

  localparam int unsigned KIND_W        = 1;
  localparam int unsigned SLOT_W        = 2;
  localparam int unsigned KEY_IDX_W     = 4;
  localparam int unsigned FRAME_W       = 16;
  localparam int unsigned ANGLE_W       = 24;
  localparam int unsigned SEG_W         = 4;
  localparam int unsigned CNT_W         = KEY_IDX_W + 1;
  localparam int unsigned QUO_W         = ANGLE_W;
  localparam int unsigned PROD_W        = ANGLE_W + FRAME_W;
  localparam int unsigned DIV_CNT_W     = $clog2(QUO_W);

  localparam int unsigned NUM_ANIMS_DEF     = 4;
  localparam int unsigned KEYS_PER_ANIM_DEF = 16;

  localparam logic [KIND_W-1:0] KIND_WRITE = 1'b0;
  localparam logic [KIND_W-1:0] KIND_EVAL  = 1'b1;

  typedef struct packed {
    logic [KIND_W-1:0]         kind;
    logic [SLOT_W-1:0]         anim_slot;
    logic [KEY_IDX_W-1:0]      key_index;
    logic [FRAME_W-1:0]        key_frame;
    logic signed [ANGLE_W-1:0] key_angle;
    logic                      last_key;
    logic [FRAME_W-1:0]        frame_number;
  } kai_in_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] angle;
    logic                      updated;
    logic [SEG_W-1:0]          segment;
  } kai_out_t;

  typedef struct packed {
    logic [FRAME_W-1:0]        frame;
    logic signed [ANGLE_W-1:0] angle;
  } kai_key_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_LAST,
    ST_RD_FIRST,
    ST_CHK_FIRST,
    ST_SCAN,
    ST_MUL,
    ST_DIV,
    ST_HIT,
    ST_MISS
  } kai_state_e;

  // controller -> datapath
  typedef struct packed {
    logic wr_key;      // store keyframe from the input transfer
    logic load_eval;   // latch frame number and key count
    logic idx_zero;
    logic cap_last;    // capture frame of the last key
    logic idx_inc;
    logic load_first;  // prev <= key 0, seg <= 0
    logic load_next;   // prev <= current key, seg++
    logic load_sub;
    logic load_mul;
    logic div_step;
    logic out_hit;
    logic out_miss;
  } kai_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic eval_ok;
    logic range_ok;
    logic hit;
    logic scan_end;
    logic div_done;
    logic out_free;
  } kai_sts_t;

endpackage

// ===== sv/keyframe_angle_interpolator.sv =====
// Keyframe angle interpolator.
// Input channel (in_valid_i / in_stall_o, payload in_data_i): a write transfer
// (kind 0) stores one keyframe; with last_key set it also sets the table's key
// count to key_index + 1. An evaluate transfer (kind 1) looks up frame_number
// in the table chosen by the active_animation register (cfg_we_i/cfg_wdata_i,
// write only while idle) and yields one result on the output channel
// (out_valid_o / out_stall_i, payload out_data_o). Writes yield nothing.
// A write is stored straight from idle. An evaluate reads the last and first key
// of the table, checks the frame against them, scans the keys one per step until
// the segment is found, multiplies, runs a radix-2 restoring divider for the 24
// quotient bits and hands the result on. A miss comes from a frame outside the
// keys, fewer than two keys or a bad active table. One item is in work at a time;
// sequencer and single key-store read port set the rate, the divider dominates.
// The output register frees the input side: a new item is taken while a
// result waits, and a finished result waits in its own state while the
// receiver stalls. Reset clears key counts, last angle, active table and
// output valid; the key store itself is not cleared and needs no sweep.
module keyframe_angle_interpolator #(
  parameter int unsigned NUM_ANIMS     = kai_pkg::NUM_ANIMS_DEF,
  parameter int unsigned KEYS_PER_ANIM = kai_pkg::KEYS_PER_ANIM_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [kai_pkg::SLOT_W-1:0]    cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  kai_pkg::kai_in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output kai_pkg::kai_out_t             out_data_o
);
  import kai_pkg::*;

  kai_cmd_t cmd;   // sequencer commands
  kai_sts_t sts;   // datapath compare and progress flags

  // sequencer: table reads, key scan, divide steps, result hand-off
  kai_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_kind_i  (in_data_i.kind),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // key store, counts, multiplier, divider and output register
  kai_datapath #(
    .NUM_ANIMS     (NUM_ANIMS),
    .KEYS_PER_ANIM (KEYS_PER_ANIM)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

// ===== sv/kai_ctrl.sv =====
module kai_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic [kai_pkg::KIND_W-1:0]      in_kind_i,
  output logic                            in_stall_o,
  input  kai_pkg::kai_sts_t               sts_i,
  output kai_pkg::kai_cmd_t               cmd_o
);
  import kai_pkg::*;

  kai_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && in_kind_i == KIND_EVAL) begin
          state_d = sts_i.eval_ok ? ST_RD_LAST : ST_MISS;
        end
      end
      ST_RD_LAST:  state_d = ST_RD_FIRST;
      ST_RD_FIRST: state_d = ST_CHK_FIRST;
      ST_CHK_FIRST: begin
        state_d = sts_i.range_ok ? ST_SCAN : ST_MISS;
      end
      ST_SCAN: begin
        priority if (sts_i.hit) begin
          state_d = ST_MUL;
        end else if (sts_i.scan_end) begin
          state_d = ST_MISS;
        end
      end
      ST_MUL: state_d = ST_DIV;
      ST_DIV: begin
        if (sts_i.div_done) begin
          state_d = ST_HIT;
        end
      end
      ST_HIT, ST_MISS: begin
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.wr_key    = (in_kind_i == KIND_WRITE);
          cmd_o.load_eval = (in_kind_i == KIND_EVAL);
        end
      end
      ST_RD_LAST:  cmd_o.idx_zero = 1'b1;
      ST_RD_FIRST: begin
        cmd_o.cap_last = 1'b1;
        cmd_o.idx_inc  = 1'b1;
      end
      ST_CHK_FIRST: begin
        cmd_o.load_first = sts_i.range_ok;
        cmd_o.idx_inc    = sts_i.range_ok;
      end
      ST_SCAN: begin
        priority if (sts_i.hit) begin
          cmd_o.load_sub = 1'b1;
        end else if (!sts_i.scan_end) begin
          cmd_o.load_next = 1'b1;
          cmd_o.idx_inc   = 1'b1;
        end
      end
      ST_MUL:  cmd_o.load_mul = 1'b1;
      ST_DIV:  cmd_o.div_step = 1'b1;
      ST_HIT:  cmd_o.out_hit  = sts_i.out_free;
      ST_MISS: cmd_o.out_miss = sts_i.out_free;
      default: cmd_o = '0;
    endcase
  end

  a_eval_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && in_valid_i && in_kind_i == KIND_EVAL) |=> in_stall_o)
    else $error("input not stalled after evaluate transfer");

  a_mul_to_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL) |=> (state_q == ST_DIV))
    else $error("divider not started after multiply");

  a_div_to_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && sts_i.div_done) |=> (state_q == ST_HIT))
    else $error("divide finished without result");

endmodule

// ===== sv/kai_datapath.sv =====
module kai_datapath #(
  parameter int unsigned NUM_ANIMS     = kai_pkg::NUM_ANIMS_DEF,
  parameter int unsigned KEYS_PER_ANIM = kai_pkg::KEYS_PER_ANIM_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [kai_pkg::SLOT_W-1:0]    cfg_wdata_i,
  input  kai_pkg::kai_in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output kai_pkg::kai_out_t             out_data_o,
  input  kai_pkg::kai_cmd_t             cmd_i,
  output kai_pkg::kai_sts_t             sts_o
);
  import kai_pkg::*;

  localparam int unsigned KEY_AW  = $clog2(KEYS_PER_ANIM);
  localparam int unsigned DEPTH   = NUM_ANIMS * KEYS_PER_ANIM;
  localparam int unsigned ADDR_W  = $clog2(DEPTH);
  localparam int unsigned ANIM_IW = (NUM_ANIMS > 1) ? $clog2(NUM_ANIMS) : 1;

  // key store, read every cycle at the active table + idx
  kai_key_t mem [DEPTH];
  kai_key_t rd_q;

  logic [SLOT_W-1:0]  active_anim_q;
  logic [CNT_W-1:0]   counts_q [NUM_ANIMS];
  logic [ANGLE_W-1:0] last_angle_q, last_angle_d;

  logic [FRAME_W-1:0] frame_q, frame_d;
  logic [FRAME_W-1:0] last_frame_q, last_frame_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [KEY_AW-1:0]  idx_q, idx_d;
  logic [KEY_AW-1:0]  seg_q, seg_d;
  kai_key_t           prev_q, prev_d;

  logic               neg_q, neg_d;
  logic               zero_span_q, zero_span_d;
  logic [ANGLE_W-1:0] mag_q, mag_d;
  logic [FRAME_W-1:0] df_q, df_d;
  logic [FRAME_W-1:0] span_q, span_d;
  logic [FRAME_W-1:0] rem_q, rem_d;
  logic [QUO_W-1:0]   dvd_q, dvd_d;
  logic [DIV_CNT_W-1:0] div_cnt_q, div_cnt_d;

  logic     out_valid_q, out_valid_d;
  kai_out_t out_q, out_d;

  logic              wr_ok;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [CNT_W-1:0]  count_sel;
  logic signed [ANGLE_W:0] diff;
  logic [PROD_W-1:0] prod;
  logic [FRAME_W:0]  rem_sh;
  logic              ge;
  logic [QUO_W-1:0]  quo;
  logic signed [ANGLE_W:0] quo_s;
  logic signed [ANGLE_W:0] res;

  assign wr_ok   = (32'(in_data_i.anim_slot) < NUM_ANIMS)
                && (32'(in_data_i.key_index) < KEYS_PER_ANIM);
  assign wr_addr = ADDR_W'(32'(in_data_i.anim_slot) * KEYS_PER_ANIM
                 + 32'(in_data_i.key_index));
  assign rd_addr = ADDR_W'(32'(active_anim_q) * KEYS_PER_ANIM + 32'(idx_q));
  assign count_sel = counts_q[ANIM_IW'(active_anim_q)];

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_key && wr_ok) begin
      mem[wr_addr] <= '{frame: in_data_i.key_frame, angle: in_data_i.key_angle};
    end
    rd_q <= mem[rd_addr];
  end

  // interpolation arithmetic
  assign diff   = {rd_q.angle[ANGLE_W-1], rd_q.angle}
                - {prev_q.angle[ANGLE_W-1], prev_q.angle};
  assign prod   = mag_q * df_q;
  assign rem_sh = {rem_q, dvd_q[QUO_W-1]};
  assign ge     = rem_sh >= {1'b0, span_q};
  assign quo    = zero_span_q ? '0 : dvd_q;
  assign quo_s  = neg_q ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
  assign res    = {prev_q.angle[ANGLE_W-1], prev_q.angle} + quo_s;

  always_comb begin
    frame_d      = frame_q;
    last_frame_d = last_frame_q;
    count_d      = count_q;
    idx_d        = idx_q;
    seg_d        = seg_q;
    prev_d       = prev_q;
    neg_d        = neg_q;
    zero_span_d  = zero_span_q;
    mag_d        = mag_q;
    df_d         = df_q;
    span_d       = span_q;
    rem_d        = rem_q;
    dvd_d        = dvd_q;
    div_cnt_d    = div_cnt_q;
    out_d        = out_q;
    last_angle_d = last_angle_q;
    out_valid_d  = out_valid_q && out_stall_i;

    if (cmd_i.load_eval) begin
      frame_d = in_data_i.frame_number;
      count_d = count_sel;
      idx_d   = KEY_AW'(count_sel - CNT_W'(1));
    end
    if (cmd_i.idx_zero) begin
      idx_d = '0;
    end
    if (cmd_i.cap_last) begin
      last_frame_d = rd_q.frame;
    end
    if (cmd_i.idx_inc) begin
      idx_d = idx_q + KEY_AW'(1);
    end
    if (cmd_i.load_first) begin
      prev_d = rd_q;
      seg_d  = '0;
    end
    if (cmd_i.load_next) begin
      prev_d = rd_q;
      seg_d  = seg_q + KEY_AW'(1);
    end
    if (cmd_i.load_sub) begin
      neg_d       = diff[ANGLE_W];
      mag_d       = diff[ANGLE_W] ? ANGLE_W'(-diff) : ANGLE_W'(diff);
      df_d        = frame_q - prev_q.frame;
      span_d      = rd_q.frame - prev_q.frame;
      zero_span_d = (rd_q.frame == prev_q.frame);
    end
    if (cmd_i.load_mul) begin
      // quotient < 2^QUO_W, so the high part is already below the divisor
      rem_d     = prod[PROD_W-1:QUO_W];
      dvd_d     = prod[QUO_W-1:0];
      div_cnt_d = '0;
    end
    if (cmd_i.div_step) begin
      rem_d     = ge ? FRAME_W'(rem_sh - {1'b0, span_q}) : rem_sh[FRAME_W-1:0];
      dvd_d     = {dvd_q[QUO_W-2:0], ge};
      div_cnt_d = div_cnt_q + DIV_CNT_W'(1);
    end
    if (cmd_i.out_hit) begin
      out_d.angle   = res[ANGLE_W-1:0];
      out_d.updated = 1'b1;
      out_d.segment = SEG_W'(seg_q);
      last_angle_d  = res[ANGLE_W-1:0];
      out_valid_d   = 1'b1;
    end
    if (cmd_i.out_miss) begin
      out_d.angle   = last_angle_q;
      out_d.updated = 1'b0;
      out_d.segment = '0;
      out_valid_d   = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    frame_q      <= frame_d;
    last_frame_q <= last_frame_d;
    count_q      <= count_d;
    idx_q        <= idx_d;
    seg_q        <= seg_d;
    prev_q       <= prev_d;
    neg_q        <= neg_d;
    zero_span_q  <= zero_span_d;
    mag_q        <= mag_d;
    df_q         <= df_d;
    span_q       <= span_d;
    rem_q        <= rem_d;
    dvd_q        <= dvd_d;
    div_cnt_q    <= div_cnt_d;
    out_q        <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_anim_q <= '0;
      last_angle_q  <= '0;
      out_valid_q   <= 1'b0;
      for (int i = 0; i < NUM_ANIMS; i++) begin
        counts_q[i] <= '0;
      end
    end else begin
      last_angle_q <= last_angle_d;
      out_valid_q  <= out_valid_d;
      if (cfg_we_i) begin
        active_anim_q <= cfg_wdata_i;
      end
      if (cmd_i.wr_key && wr_ok && in_data_i.last_key) begin
        counts_q[ANIM_IW'(in_data_i.anim_slot)] <=
          CNT_W'(in_data_i.key_index) + CNT_W'(1);
      end
    end
  end

  assign sts_o.eval_ok  = (32'(active_anim_q) < NUM_ANIMS) && (count_sel >= CNT_W'(2));
  assign sts_o.range_ok = (frame_q >= rd_q.frame) && (frame_q <= last_frame_q);
  assign sts_o.hit      = (prev_q.frame <= frame_q) && (rd_q.frame >= frame_q);
  assign sts_o.scan_end = (CNT_W'(seg_q) + CNT_W'(2)) == count_q;
  assign sts_o.div_done = div_cnt_q == DIV_CNT_W'(QUO_W - 1);
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_last_angle_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(last_angle_q) |-> $past(cmd_i.out_hit))
    else $error("last angle changed without an interpolated result");

  a_quo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.out_hit && !zero_span_q) |-> (dvd_q <= mag_q))
    else $error("interpolation step exceeds angle difference");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(out_q)))
    else $error("stalled result changed");

endmodule
